// ===== hw/rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg: shared types for the LRU slot pool allocator
// Field widths, the slot contents held by each ring cell, the scan record and
// the write command broadcast to the ring.
// ----------------------------------------------------------------------------
package lsp_pkg;

    localparam int OWNER_W = 16;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 6;
    localparam int IN_DATA_W  = 56;  // 54 bits of fields, padded to 7 bytes
    localparam int OUT_DATA_W = 24;

    // request kinds carried on s_axis_tuser
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_EVICT = 1'b1;

    typedef struct packed {
        logic               in_use;
        logic [OWNER_W-1:0] holder;
        logic [STAMP_W-1:0] stamp;
    } slot_t;

    // running result of one pass round the ring
    typedef struct packed {
        logic               found_free;
        logic               found_old;
        logic               hit;          // evict target seen
        logic               best_use;     // chosen slot held an owner
        logic [OWNER_W-1:0] best_holder;
        logic [STAMP_W-1:0] best_stamp;
    } scan_rec_t;

    typedef struct packed {
        logic               en;
        logic               in_use;
        logic               load;         // also write holder and stamp
        logic [OWNER_W-1:0] holder;
        logic [STAMP_W-1:0] stamp;
    } cell_wr_t;

endpackage

// ===== hw/rtl/lsp_cell.sv =====
// ----------------------------------------------------------------------------
// lsp_cell: one cell of the slot ring
// Holds one slot's state. Passes it on to the neighbour while the ring turns,
// and takes a write when selected while the ring stands still.
// ----------------------------------------------------------------------------
module lsp_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  lsp_pkg::slot_t   cell_in,
    input  logic             sel,
    input  lsp_pkg::cell_wr_t wr,
    output lsp_pkg::slot_t   cell_out
);
    import lsp_pkg::*;

    logic               in_use_reg;
    logic [OWNER_W-1:0] holder_reg;
    logic [STAMP_W-1:0] stamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= 1'b0;
        end else if (shift_en) begin
            in_use_reg <= cell_in.in_use;
        end else if (wr.en && sel) begin
            in_use_reg <= wr.in_use;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            holder_reg <= cell_in.holder;
            stamp_reg  <= cell_in.stamp;
        end else if (wr.en && sel && wr.load) begin
            holder_reg <= wr.holder;
            stamp_reg  <= wr.stamp;
        end
    end

    assign cell_out = '{in_use: in_use_reg, holder: holder_reg, stamp: stamp_reg};

endmodule

// ===== hw/rtl/lsp_head.sv =====
// ----------------------------------------------------------------------------
// lsp_head: comparator at the head of the slot ring
// Sees one slot per cycle and folds it into the scan record: first free slot,
// else the oldest stamp not later than the request's frame, or the evict target.
// ----------------------------------------------------------------------------
module lsp_head #(
    parameter int IDX_W = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        step,
    input  logic [IDX_W-1:0]            idx,
    input  lsp_pkg::slot_t              slot,
    input  logic                        mode,
    input  logic [lsp_pkg::STAMP_W-1:0] frame_now,
    input  logic [lsp_pkg::SLOT_W-1:0]  target_slot,
    output lsp_pkg::scan_rec_t          rec,
    output logic [IDX_W-1:0]            best_idx
);
    import lsp_pkg::*;

    localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    scan_rec_t        rec_reg, rec_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             is_target;
    logic             not_later;
    logic             older;

    assign is_target = (CMP_W'(idx) == CMP_W'(target_slot));
    assign not_later = (slot.stamp <= frame_now);
    assign older     = !rec_reg.found_old || (slot.stamp < rec_reg.best_stamp);

    always_comb begin
        rec_next      = rec_reg;
        best_idx_next = best_idx_reg;
        if (mode == MODE_EVICT) begin
            if (is_target) begin
                rec_next.hit         = 1'b1;
                rec_next.best_use    = slot.in_use;
                rec_next.best_holder = slot.holder;
                best_idx_next        = idx;
            end
        end else if (!rec_reg.found_free) begin
            if (!slot.in_use) begin
                rec_next.found_free = 1'b1;
                rec_next.best_use   = 1'b0;
                best_idx_next       = idx;
            end else if (not_later && older) begin
                rec_next.found_old   = 1'b1;
                rec_next.best_use    = 1'b1;
                rec_next.best_holder = slot.holder;
                rec_next.best_stamp  = slot.stamp;
                best_idx_next        = idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            rec_reg.best_holder <= rec_next.best_holder;
            rec_reg.best_stamp  <= rec_next.best_stamp;
            best_idx_reg        <= best_idx_next;
        end
        if (!aresetn || start) begin
            rec_reg.found_free <= 1'b0;
            rec_reg.found_old  <= 1'b0;
            rec_reg.hit        <= 1'b0;
            rec_reg.best_use   <= 1'b0;
        end else if (step) begin
            rec_reg.found_free <= rec_next.found_free;
            rec_reg.found_old  <= rec_next.found_old;
            rec_reg.hit        <= rec_next.hit;
            rec_reg.best_use   <= rec_next.best_use;
        end
    end

    assign rec      = rec_reg;
    assign best_idx = best_idx_reg;

endmodule

// ===== hw/rtl/lru_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// lru_slot_pool_allocator: slot pool with oldest-stamp replacement
// Allocates slots to owners and frees named slots, one request at a time.
// ----------------------------------------------------------------------------
// The slots sit in a ring of cells that turns once per request past a single
// comparator. After the input transfer the ring rotates back home in ST_SCAN,
// and ST_DONE then writes the chosen slot and loads the result register.
// s_axis is ready again once the state is back in ST_IDLE. A new request is
// taken while an earlier result still waits on m_axis; a request that
// finishes while the result register is still full holds in its last step
// until that result is taken. Allocate picks the lowest free slot, else the
// lowest slot with the oldest stamp not later than frame_now, and fails
// (grant_ok low) when none qualifies. Evict frees the slot named; a target
// beyond the pool fails. chosen_slot carries the low six bits of the slot
// number.
module lru_slot_pool_allocator #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // owner_index [15:0], frame_now [47:16], target_slot [53:48], zero pad
    input  logic [lsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode [0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // chosen_slot [5:0], grant_ok [6], displaced_valid [7],
    // displaced_owner [23:8]
    output logic [lsp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import lsp_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic               mode_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [SLOT_W-1:0]  target_reg;
    logic               m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    slot_t              slot_q [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] sel;
    cell_wr_t           wr;
    scan_rec_t          rec;
    logic [IDX_W-1:0]   best_idx;
    logic [CMP_W-1:0]   pick_ext;

    logic               accept;
    logic               scan_last;
    logic               out_free;
    logic               res_ok;
    logic               res_dv;
    logic [SLOT_W-1:0]  res_slot;
    logic [OWNER_W-1:0] res_owner;
    logic               res_write;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign scan_last     = (scan_cnt_reg == IDX_W'(SLOT_COUNT - 1));
    assign out_free      = !m_valid_reg || m_axis_tready;

    // ring: cell i takes from cell i+1, cell 0 is the head
    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_ring
        assign sel[i] = (best_idx == IDX_W'(i));
        lsp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (state_reg == ST_SCAN),
            .cell_in  (slot_q[(i + 1) % SLOT_COUNT]),
            .sel      (sel[i]),
            .wr       (wr),
            .cell_out (slot_q[i])
        );
    end

    lsp_head #(.IDX_W(IDX_W)) u_head (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (accept),
        .step        (state_reg == ST_SCAN),
        .idx         (scan_cnt_reg),
        .slot        (slot_q[0]),
        .mode        (mode_reg),
        .frame_now   (now_reg),
        .target_slot (target_reg),
        .rec         (rec),
        .best_idx    (best_idx)
    );

    assign pick_ext = CMP_W'(best_idx);

    always_comb begin
        if (mode_reg == MODE_EVICT) begin
            res_ok    = rec.hit;
            res_slot  = target_reg;
            res_dv    = rec.hit && rec.best_use;
            res_write = rec.hit;
        end else begin
            res_ok    = rec.found_free || rec.found_old;
            res_slot  = res_ok ? pick_ext[SLOT_W-1:0] : '0;
            res_dv    = !rec.found_free && rec.found_old;
            res_write = res_ok;
        end
        res_owner = res_dv ? rec.best_holder : '0;
    end

    assign wr.en     = (state_reg == ST_DONE) && out_free && res_write;
    assign wr.in_use = (mode_reg == MODE_ALLOC);
    assign wr.load   = (mode_reg == MODE_ALLOC);
    assign wr.holder = owner_reg;
    assign wr.stamp  = now_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one loads now
            if (m_valid_reg && m_axis_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        mode_reg     <= s_axis_tuser;
                        owner_reg    <= s_axis_tdata[15:0];
                        now_reg      <= s_axis_tdata[47:16];
                        target_reg   <= s_axis_tdata[53:48];
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // advance until the ring is back home
                    if (scan_last) begin
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_DONE;
                    end else begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    // hold until the result register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {res_owner, res_dv, res_ok, res_slot};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_ring_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (scan_cnt_reg == '0))
        else $error("ring not at home position while idle");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start a scan");

    a_disp_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[7]) |-> m_axis_tdata[6])
        else $error("displaced owner reported on a failed request");

    a_disp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[7]) |-> (m_axis_tdata[23:8] == '0))
        else $error("displaced owner not cleared");

endmodule
